/* rtl/nsp_pkg.sv */
`timescale 1ns / 1ps
package nsp_pkg;

  typedef struct packed {
    logic [30:0] rand_a;
    logic [30:0] rand_b;
    logic [30:0] rand_c;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_beat_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GAIN   = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_t;

  localparam logic        MODE_WHITE = 1'b0;
  localparam logic [30:0] LN2X2_Q30  = 31'd1488522236;
  localparam logic [34:0] PINK_OFFSET_Q24 = 35'd13102381;

  localparam logic [19:0] POLE_Q20 [3] = '{20'd334496, 20'd813276, 20'd1007996};
  localparam logic [23:0] WEIGHT_Q24 [3] = '{24'd353871, 24'd1193444, 24'd11555066};

endpackage

/* rtl/nsp_chan_if.sv */
`timescale 1ns / 1ps
interface nsp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/noise_shaper_white_pink_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                      Beat taken when
// in_chan   in   rand_a, rand_b, rand_c       valid & ready
// out_chan  out  sample (Q8.24), last         valid & ready
// cfg_chan  in   index, data                  valid & ready (always ready)
//
// One 40x33 multiplier and a step counter serve all work.
// White: per accepted pair, a normalize shift, then 30 log squarings, two 32-step roots and
// two 32-step divides. A rejected pair returns to idle with no result; pink runs three
// filters, each through S_PA, S_PB, S_PC and S_PD, then S_PZ and the final steps.
// Reset is synchronous; registers take their defaults and filter state clears.
// A result waits in the output register; the final step stalls only while it is full.
module noise_shaper_white_pink_unit #(
  parameter int RAND_BITS = 31
) (
  input logic clk,
  input logic rst_n,
  nsp_chan_if.sink   in_chan,
  nsp_chan_if.source out_chan,
  nsp_chan_if.sink   cfg_chan
);

  localparam int F = RAND_BITS - 1;
  localparam int XSH = 40 - RAND_BITS;
  localparam logic [31:0] MASK = 32'hFFFF_FFFF >> (32 - RAND_BITS);
  localparam logic [32:0] HALF = 33'd1 << F;
  localparam logic [63:0] SLIM = 64'd1 << (2 * F);
  localparam logic [6:0]  TWO_F = 7'(2 * F);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ1, S_SQ2, S_SQ3, S_CHK, S_NORM, S_LOGA, S_LOGB, S_NEG, S_T1, S_T2,
    S_SQRT, S_ROOT_INIT, S_DIV_INIT, S_DIV, S_G1, S_G2, S_FIN1, S_FIN2,
    S_PA, S_PB, S_PC, S_PD, S_PZ
  } state_t;

  state_t state_r, state_nxt;
  logic        mode_r, mode_nxt;
  logic signed [31:0] gain_r, gain_nxt, ofs_r, ofs_nxt;
  logic signed [32:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [39:0] x_r [3];
  logic [39:0] x_nxt [3];
  logic [39:0] lp_r [3];
  logic [39:0] lp_nxt [3];
  logic [63:0] s_r, s_nxt, norm_r, norm_nxt, t_r, t_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [30:0] m_r, m_nxt;
  logic [29:0] frac_r, frac_nxt;
  logic [4:0]  cnt_r, cnt_nxt, zs_r, zs_nxt;
  logic [36:0] neg_r, neg_nxt;
  logic [63:0] sq_v_r, sq_v_nxt, sq_q_r, sq_q_nxt;
  logic        sq_sel_r, sq_sel_nxt;
  logic [31:0] radius_r, radius_nxt, root_r, root_nxt;
  logic [31:0] rem_r, rem_nxt, numlo_r, numlo_nxt, quo_r, quo_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic signed [34:0] zv_r, zv_nxt;
  logic [39:0] ma_r, ma_nxt;
  logic [32:0] mb_r, mb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] out_sample_r, out_sample_nxt;
  logic        out_last_r, out_last_nxt, out_valid_r, out_valid_nxt;

  logic [72:0] prod;
  assign prod = 73'(ma_r) * 73'(mb_r);

  nsp_pkg::in_beat_t  in_beat;
  nsp_pkg::cfg_beat_t cfg_beat;
  assign in_beat  = in_chan.data;
  assign cfg_beat = cfg_chan.data;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = '{sample: out_sample_r, last: out_last_r};

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : 33'(v);
    return a[31:0];
  endfunction

  logic [31:0] ra, rb, rc;
  logic [32:0] mm;
  logic [6:0]  ex;
  logic [63:0] bitv, trial, num;
  logic [32:0] cand;
  logic [64:0] gsum;
  logic [33:0] gmag;
  logic [60:0] pc_sum;
  logic [39:0] nv;
  logic [72:0] psum;
  logic [48:0] pm;
  logic signed [50:0] ps, pres;
  logic signed [32:0] dsel;
  logic [34:0] zmag;

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    gain_nxt = gain_r;
    ofs_nxt = ofs_r;
    d1_nxt = d1_r;
    d2_nxt = d2_r;
    x_nxt = x_r;
    lp_nxt = lp_r;
    s_nxt = s_r;
    norm_nxt = norm_r;
    t_nxt = t_r;
    sh_nxt = sh_r;
    m_nxt = m_r;
    frac_nxt = frac_r;
    cnt_nxt = cnt_r;
    zs_nxt = zs_r;
    neg_nxt = neg_r;
    sq_v_nxt = sq_v_r;
    sq_q_nxt = sq_q_r;
    sq_sel_nxt = sq_sel_r;
    radius_nxt = radius_r;
    root_nxt = root_r;
    rem_nxt = rem_r;
    numlo_nxt = numlo_r;
    quo_nxt = quo_r;
    idx_nxt = idx_r;
    zv_nxt = zv_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r;

    ra = {1'b0, in_beat.rand_a} & MASK;
    rb = {1'b0, in_beat.rand_b} & MASK;
    rc = {1'b0, in_beat.rand_c} & MASK;
    mm = prod[62:30];
    ex = TWO_F + 7'(sh_r) - 7'd63;
    bitv = 64'h4000_0000_0000_0000 >> {cnt_r, 1'b0};
    trial = sq_q_r + bitv;
    dsel = idx_r[0] ? d2_r : d1_r;
    num = 64'(mag33(dsel)) << (6'(zs_r) + 6'd30);
    cand = {rem_r, numlo_r[31]};
    gsum = {1'b0, prod[63:0]} + (65'd1 << 33);
    gmag = {3'b0, gsum[64:34]};
    pc_sum = 61'(t_r) + 61'(prod[63:0]);
    nv = pc_sum[59:20];
    zmag = zv_r[34] ? 35'(-zv_r) : 35'(zv_r);
    psum = prod + (73'd1 << 23);
    pm = psum[72:24];
    ps = (zv_r[34] != gain_r[31]) ? -51'(signed'({2'b0, pm})) : 51'(signed'({2'b0, pm}));
    pres = ps + 51'(ofs_r);

    if (out_chan.valid && out_chan.ready) out_valid_nxt = 1'b0;

    if (cfg_chan.valid) begin
      unique case (cfg_beat.index)
        nsp_pkg::REG_MODE:   mode_nxt = cfg_beat.data[0];
        nsp_pkg::REG_GAIN:   gain_nxt = signed'(cfg_beat.data);
        nsp_pkg::REG_OFFSET: ofs_nxt = signed'(cfg_beat.data);
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          d1_nxt = signed'({1'b0, ra} - HALF);
          d2_nxt = signed'({1'b0, rb} - HALF);
          x_nxt[0] = {8'b0, ra} << XSH;
          x_nxt[1] = {8'b0, rb} << XSH;
          x_nxt[2] = {8'b0, rc} << XSH;
          idx_nxt = '0;
          acc_nxt = '0;
          state_nxt = (mode_r == nsp_pkg::MODE_WHITE) ? S_SQ1 : S_PA;
        end
      end
      S_SQ1: begin
        ma_nxt = 40'(mag33(d1_r));
        mb_nxt = 33'(mag33(d1_r));
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        s_nxt = prod[63:0];
        ma_nxt = 40'(mag33(d2_r));
        mb_nxt = 33'(mag33(d2_r));
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        s_nxt = s_r + prod[63:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        norm_nxt = s_r;
        sh_nxt = '0;
        // drop pairs at the origin or on or outside the unit circle
        state_nxt = (s_r == '0 || s_r >= SLIM) ? S_IDLE : S_NORM;
      end
      S_NORM: begin
        if (norm_r[63]) begin
          m_nxt = norm_r[63:33];
          frac_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_LOGA;
        end else begin
          norm_nxt = norm_r << 1;
          sh_nxt = sh_r + 6'd1;
        end
      end
      S_LOGA: begin
        ma_nxt = 40'(m_r);
        mb_nxt = 33'(m_r);
        state_nxt = S_LOGB;
      end
      S_LOGB: begin
        frac_nxt = {frac_r[28:0], mm[31]};
        m_nxt = mm[31] ? mm[31:1] : mm[30:0];
        cnt_nxt = cnt_r + 5'd1;
        state_nxt = (cnt_r == 5'd29) ? S_NEG : S_LOGA;
      end
      S_NEG: begin
        neg_nxt = {ex, 30'b0} - {7'b0, frac_r};
        ma_nxt = 40'(neg_nxt[36:30]);
        mb_nxt = 33'(nsp_pkg::LN2X2_Q30);
        state_nxt = S_T1;
      end
      S_T1: begin
        t_nxt = prod[63:0];
        ma_nxt = 40'(neg_r[29:0]);
        mb_nxt = 33'(nsp_pkg::LN2X2_Q30);
        state_nxt = S_T2;
      end
      S_T2: begin
        sq_v_nxt = (t_r + 64'(prod[72:30])) << 26;
        sq_q_nxt = '0;
        cnt_nxt = '0;
        sq_sel_nxt = 1'b0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_v_r >= trial) begin
          sq_v_nxt = sq_v_r - trial;
          sq_q_nxt = (sq_q_r >> 1) + bitv;
        end else begin
          sq_q_nxt = sq_q_r >> 1;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          if (!sq_sel_r) begin
            radius_nxt = sq_q_nxt[31:0];
            state_nxt = S_ROOT_INIT;
          end else begin
            root_nxt = sq_q_nxt[31:0];
            idx_nxt = '0;
            state_nxt = S_DIV_INIT;
          end
        end
      end
      S_ROOT_INIT: begin
        // even shift that lifts s to at least 2^60
        zs_nxt = (sh_r <= 6'd3) ? 5'd0 : 5'((sh_r - 6'd2) >> 1);
        sq_v_nxt = s_r << {zs_nxt, 1'b0};
        sq_q_nxt = '0;
        cnt_nxt = '0;
        sq_sel_nxt = 1'b1;
        state_nxt = S_SQRT;
      end
      S_DIV_INIT: begin
        rem_nxt = num[63:32];
        numlo_nxt = num[31:0];
        quo_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cand >= {1'b0, root_r}) begin
          rem_nxt = 32'(cand - {1'b0, root_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = cand[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        numlo_nxt = numlo_r << 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_G1;
      end
      S_G1: begin
        ma_nxt = 40'(radius_r);
        mb_nxt = 33'(quo_r);
        state_nxt = S_G2;
      end
      S_G2: begin
        zv_nxt = dsel[32] ? -35'(signed'({1'b0, gmag})) : 35'(signed'({1'b0, gmag}));
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        ma_nxt = 40'(zmag);
        mb_nxt = 33'(mag33(33'(gain_r)));
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt = mode_r | idx_r[0];
          if (pres > 51'sd2147483647) out_sample_nxt = 32'h7FFF_FFFF;
          else if (pres < -51'sd2147483648) out_sample_nxt = 32'h8000_0000;
          else out_sample_nxt = pres[31:0];
          if (mode_r == nsp_pkg::MODE_WHITE && !idx_r[0]) begin
            idx_nxt = 2'd1;
            state_nxt = S_DIV_INIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PA: begin
        ma_nxt = lp_r[idx_r];
        mb_nxt = 33'(nsp_pkg::POLE_Q20[idx_r]);
        state_nxt = S_PB;
      end
      S_PB: begin
        t_nxt = prod[63:0];
        ma_nxt = x_r[idx_r];
        mb_nxt = 33'(21'h10_0000 - 21'(nsp_pkg::POLE_Q20[idx_r]));
        state_nxt = S_PC;
      end
      S_PC: begin
        lp_nxt[idx_r] = nv;
        ma_nxt = nv;
        mb_nxt = 33'(nsp_pkg::WEIGHT_Q24[idx_r]);
        state_nxt = S_PD;
      end
      S_PD: begin
        acc_nxt = acc_r + prod[63:0];
        if (idx_r == 2'd2) begin
          state_nxt = S_PZ;
        end else begin
          idx_nxt = idx_r + 2'd1;
          state_nxt = S_PA;
        end
      end
      S_PZ: begin
        zv_nxt = signed'(35'(acc_r[63:39]) - nsp_pkg::PINK_OFFSET_Q24);
        state_nxt = S_FIN1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= 1'b0;
      gain_r <= 32'sh0100_0000;
      ofs_r <= '0;
      lp_r <= '{default: '0};
      out_valid_r <= 1'b0;
      idx_r <= '0;
      cnt_r <= '0;
      sq_sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      gain_r <= gain_nxt;
      ofs_r <= ofs_nxt;
      lp_r <= lp_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      sq_sel_r <= sq_sel_nxt;
    end
    d1_r <= d1_nxt;
    d2_r <= d2_nxt;
    x_r <= x_nxt;
    s_r <= s_nxt;
    norm_r <= norm_nxt;
    t_r <= t_nxt;
    sh_r <= sh_nxt;
    m_r <= m_nxt;
    frac_r <= frac_nxt;
    zs_r <= zs_nxt;
    neg_r <= neg_nxt;
    sq_v_r <= sq_v_nxt;
    sq_q_r <= sq_q_nxt;
    radius_r <= radius_nxt;
    root_r <= root_nxt;
    rem_r <= rem_nxt;
    numlo_r <= numlo_nxt;
    quo_r <= quo_nxt;
    zv_r <= zv_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r <= out_last_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while sequencer busy");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(state_r == S_FIN2))
    else $error("result raised outside final stage");

  a_first_is_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.data.last) |-> (mode_r == nsp_pkg::MODE_WHITE))
    else $error("non-final result in pink mode");

endmodule
